// ----- rtl/icdf_pkg.sv -----
`default_nettype none

package icdf_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int POS_W  = 10;
  localparam int CDF_W  = 17;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 2;
  localparam int PROD_W = VAL_W + CDF_W;

  localparam int QUEUE_DEPTH = 2;

  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = 1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [ST_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [ST_W-1:0] ST_FLAT   = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT    = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ENTRIES = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_INTERP  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [POS_W-1:0] entry_index;
    logic [CDF_W-1:0] entry_cdf;
    logic [VAL_W-1:0] entry_value;
    logic [CDF_W-1:0] probe_cdf;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] sampled_value;
    logic [POS_W-1:0] lower_position;
    logic [ST_W-1:0]  status;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] entries_in_use;
    logic             interpolate_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'b01,
    KIND_LOOKUP = 2'b10
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [CDF_W-1:0]  cdf;
    logic [VAL_W-1:0]  value;
    logic [CDF_W-1:0]  probe;
  } q_item_t;

  typedef struct packed {
    logic [CDF_W-1:0] cdf;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/inverse_cdf_table_sampler.sv -----
// Port group   Handshake           Payload
// item         push / full         in_item_t: opcode, entry, probe
// result       pop / empty         result_t: value, position, status
// config       psel/penable/pready paddr, pwdata, prdata
//
// A write item is written to the table as it leaves the queue. An interpolated lookup
// shows its result after the search steps (up to 10), two bracket reads, one multiply and
// a shift-subtract divide. With interpolation off or a zero-width bracket the result
// shows after the search steps and the two bracket reads.
// Synchronous reset empties queue, idles control, presets config; table is not cleared.
// A waiting result holds the next lookup; full rises once two items wait behind it.
`default_nettype none

module inverse_cdf_table_sampler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  icdf_pkg::in_item_t              item,
  output logic                            empty,
  input  logic                            pop,
  output icdf_pkg::result_t               result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [icdf_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import icdf_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_valid;
  q_item_t              q_item;
  logic                 q_take;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entries_in_use     <= CNT_W'(2);
      cfg.interpolate_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ENTRIES: cfg.entries_in_use     <= pwdata[CNT_W-1:0];
        REG_INTERP:  cfg.interpolate_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENTRIES: prdata = 32'(cfg.entries_in_use);
      REG_INTERP:  prdata = 32'(cfg.interpolate_enable);
      default:     prdata = '0;
    endcase
  end

  icdf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  icdf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// ----- rtl/icdf_front.sv -----
`default_nettype none

module icdf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  icdf_pkg::in_item_t item,
  output logic              q_valid,
  output icdf_pkg::q_item_t q_item,
  input  logic              q_take
);

  import icdf_pkg::*;

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t          slots [QUEUE_DEPTH];
  logic [QP_W-1:0]  wptr;
  logic [QP_W-1:0]  rptr;
  logic [QC_W-1:0]  count;

  q_item_t          cls;
  logic             keep;
  logic             enq;

  always_comb begin
    cls.kind  = (item.opcode == OP_LOOKUP) ? KIND_LOOKUP : KIND_WRITE;
    cls.addr  = ADDR_W'(item.entry_index);
    cls.cdf   = item.entry_cdf;
    cls.value = item.entry_value;
    cls.probe = item.probe_cdf;
    // drop writes that fall outside the table
    keep = (item.opcode == OP_LOOKUP) || (32'(item.entry_index) < 32'(TABLE_DEPTH));
  end

  assign full    = (count == QC_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rptr];
  assign enq     = push && !full && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wptr <= (wptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QP_W'(1);
      end
      if (q_take) begin
        rptr <= (rptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QP_W'(1);
      end
      if (enq && !q_take) begin
        count <= count + QC_W'(1);
      end else if (!enq && q_take) begin
        count <= count - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wptr] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/icdf_div.sv -----
`default_nettype none

module icdf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [icdf_pkg::PROD_W-1:0]  dividend,
  input  logic [icdf_pkg::CDF_W-1:0]   divisor,
  output logic                         last,
  output logic [icdf_pkg::PROD_W-1:0]  quotient
);

  import icdf_pkg::*;

  localparam int DCNT_W = $clog2(PROD_W + 1);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [PROD_W-1:0] quo;
  logic [CDF_W-1:0]  rem;
  logic [CDF_W-1:0]  dvs;

  logic [CDF_W:0]    shifted;
  logic [CDF_W-1:0]  rem_next;
  logic              q_bit;

  always_comb begin
    shifted = {rem, quo[PROD_W-1]};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = CDF_W'(shifted - {1'b0, dvs});
      q_bit    = 1'b1;
    end else begin
      rem_next = shifted[CDF_W-1:0];
      q_bit    = 1'b0;
    end
  end

  assign last     = busy && (cnt == DCNT_W'(1));
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(PROD_W);
    end else if (busy) begin
      cnt <= cnt - DCNT_W'(1);
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[PROD_W-2:0], q_bit};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/icdf_back.sv -----
`default_nettype none

module icdf_back (
  input  logic              clk,
  input  logic              rst,
  input  icdf_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  icdf_pkg::q_item_t q_item,
  output logic              q_take,
  output logic              empty,
  input  logic              pop,
  output icdf_pkg::result_t result
);

  import icdf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_LO     = 7'b0000100,
    S_HI     = 7'b0001000,
    S_MUL    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  function automatic logic [ADDR_W-1:0] midpoint(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W:1];
  endfunction

  entry_t            mem [TABLE_DEPTH];
  entry_t            rdata;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] lo_next;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] hi_next;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] mid_next;
  logic [CDF_W-1:0]  probe;
  logic [CDF_W-1:0]  cdf_lo;
  logic [VAL_W-1:0]  val_lo;
  logic [VAL_W-1:0]  mag_dv;
  logic [CDF_W-1:0]  mag_dp;
  logic [CDF_W-1:0]  mag_dc;
  logic              neg;
  logic              out_valid;
  result_t           out_item;

  logic [31:0]       n_act;
  logic [ADDR_W-1:0] hi_init;

  logic signed [CDF_W:0] dc_s;
  logic signed [CDF_W:0] dp_s;
  logic signed [VAL_W:0] dv_s;
  logic                  direct;

  logic              div_start;
  logic              div_last;
  logic [PROD_W-1:0] quotient;
  logic [PROD_W:0]   sum;

  always_comb begin
    if (cfg.entries_in_use < CNT_W'(2)) begin
      n_act = 32'd2;
    end else if (32'(cfg.entries_in_use) > 32'(TABLE_DEPTH)) begin
      n_act = 32'(TABLE_DEPTH);
    end else begin
      n_act = 32'(cfg.entries_in_use);
    end
    hi_init = ADDR_W'(n_act - 32'd1);
  end

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    raddr      = mid;
    q_take     = 1'b0;
    mem_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == KIND_WRITE) begin
            q_take = 1'b1;
            mem_we = 1'b1;
          end else if (!out_valid) begin
            q_take  = 1'b1;
            lo_next = '0;
            hi_next = hi_init;
            if (hi_init > ADDR_W'(1)) begin
              mid_next   = midpoint('0, hi_init);
              raddr      = mid_next;
              state_next = S_SEARCH;
            end else begin
              raddr      = '0;
              state_next = S_LO;
            end
          end
        end
      end
      S_SEARCH: begin
        if (rdata.cdf > probe) begin
          hi_next = mid;
        end else begin
          lo_next = mid;
        end
        if ((hi_next - lo_next) > ADDR_W'(1)) begin
          mid_next = midpoint(lo_next, hi_next);
          raddr    = mid_next;
        end else begin
          raddr      = lo_next;
          state_next = S_LO;
        end
      end
      S_LO: begin
        raddr      = hi;
        state_next = S_HI;
      end
      S_HI: begin
        state_next = direct ? S_IDLE : S_MUL;
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.addr] <= '{cdf: q_item.cdf, value: q_item.value};
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    dc_s   = $signed({1'b0, rdata.cdf}) - $signed({1'b0, cdf_lo});
    dp_s   = $signed({1'b0, probe}) - $signed({1'b0, cdf_lo});
    dv_s   = $signed({1'b0, rdata.value}) - $signed({1'b0, val_lo});
    direct = !cfg.interpolate_enable || (dc_s == '0);
  end

  assign div_start = (state == S_MUL);

  icdf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (PROD_W'(mag_dv) * PROD_W'(mag_dp)),
    .divisor  (mag_dc),
    .last     (div_last),
    .quotient (quotient)
  );

  assign sum = {1'b0, PROD_W'(val_lo)} + {1'b0, quotient};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_HI && direct) || state == S_FIN) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (q_take) begin
      probe <= q_item.probe;
    end
    if (state == S_LO) begin
      cdf_lo <= rdata.cdf;
      val_lo <= rdata.value;
    end
    if (state == S_HI) begin
      mag_dc <= dc_s[CDF_W] ? CDF_W'(-dc_s) : dc_s[CDF_W-1:0];
      mag_dp <= dp_s[CDF_W] ? CDF_W'(-dp_s) : dp_s[CDF_W-1:0];
      mag_dv <= dv_s[VAL_W] ? VAL_W'(-dv_s) : dv_s[VAL_W-1:0];
      neg    <= dv_s[VAL_W] ^ dp_s[CDF_W] ^ dc_s[CDF_W];
      if (direct) begin
        out_item.sampled_value  <= val_lo;
        out_item.lower_position <= POS_W'(lo);
        out_item.status         <= cfg.interpolate_enable ? ST_FLAT : ST_NORMAL;
      end
    end
    if (state == S_FIN) begin
      out_item.lower_position <= POS_W'(lo);
      if (neg) begin
        if (quotient > PROD_W'(val_lo)) begin
          out_item.sampled_value <= '0;
          out_item.status        <= ST_SAT;
        end else begin
          out_item.sampled_value <= VAL_W'(PROD_W'(val_lo) - quotient);
          out_item.status        <= ST_NORMAL;
        end
      end else begin
        if (sum > (PROD_W + 1)'({VAL_W{1'b1}})) begin
          out_item.sampled_value <= '1;
          out_item.status        <= ST_SAT;
        end else begin
          out_item.sampled_value <= sum[VAL_W-1:0];
          out_item.status        <= ST_NORMAL;
        end
      end
    end
  end

  assign empty  = !out_valid;
  assign result = out_item;

  a_fin_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> !out_valid)
    else $error("result slot busy when lookup finishes");

  a_search_bracket: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (mid > lo) && (mid < hi))
    else $error("search probe outside bracket");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (state == S_IDLE))
    else $error("queue read outside idle");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_HI) || ($past(state) == S_FIN))
    else $error("result raised from wrong state");

endmodule

`default_nettype wire
